[rtl/rmq_pkg.sv]
`default_nettype none

package rmq_pkg;

   // Field widths and fixed-point formats.
   localparam int MatW  = 16;             // matrix entry, Q2.14
   localparam int NumM  = 9;              // entries per matrix
   localparam int InW   = MatW * NumM;    // packed input item
   localparam int OutW  = 16;             // quaternion component, Q2.14
   localparam int NumQ  = 4;              // components per quaternion
   localparam int RspW  = OutW * NumQ;    // packed result item
   localparam int FracW = 14;             // fraction bits of 1.0
   localparam int OneQ  = 1 << FracW;

   // Internal widths.
   localparam int SumW = MatW + 2;        // signed diagonal combination
   localparam int SW   = MatW + 1;        // clamped, non-negative combination
   localparam int RtW  = 24;              // square root result
   localparam int XW   = 2 * RtW;         // square root radicand
   localparam int RemW = RtW + 2;         // square root partial remainder
   localparam int PadW = XW - SW - 2 * FracW;
   localparam int QW   = FracW + 1;       // quotient magnitude, up to 1.0
   localparam int NumW = RtW + FracW;     // dividend

   // Indexes of the off-diagonal sign flags.
   localparam int SbD32 = 0;              // m32 - m23 < 0
   localparam int SbD13 = 1;              // m13 - m31 < 0
   localparam int SbD21 = 2;              // m21 - m12 < 0
   localparam int SbP21 = 3;              // m21 + m12 < 0
   localparam int SbP13 = 4;              // m13 + m31 < 0
   localparam int SbP32 = 5;              // m32 + m23 < 0
   localparam int SbW   = 6;

   // One lane of a digit-by-digit square root: radicand still to be consumed
   // (MSB first), partial remainder and partial root.
   typedef struct packed {
      logic [XW-1:0]   x;
      logic [RemW-1:0] rem;
      logic [RtW-1:0]  root;
   } sqrt_lane_type;

   // One result bit of a floor square root.
   function automatic sqrt_lane_type sqrt_step(input sqrt_lane_type lane);
      sqrt_lane_type nxt;
      logic [RemW+1:0] acc;
      logic [RemW+1:0] trial;
      acc   = {lane.rem, lane.x[XW-1 -: 2]};
      trial = {2'b00, lane.root, 2'b01};
      nxt.x = {lane.x[XW-3:0], 2'b00};
      if (acc >= trial) begin
         nxt.rem  = RemW'(acc - trial);
         nxt.root = {lane.root[RtW-2:0], 1'b1};
      end else begin
         nxt.rem  = acc[RemW-1:0];
         nxt.root = {lane.root[RtW-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
`default_nettype none

// Rotation matrix to unit quaternion.
// The req channel carries one 3x3 matrix per item as nine signed Q2.14
// entries; the rsp channel returns one unit quaternion per item as four
// signed Q2.14 components, q0 (scalar) first.
// The work runs through a fixed pipeline: one front stage for the diagonal
// combinations and sign flags, 24 stages of square root (one root bit per
// stage, four lanes), a square stage, a sum stage, 24 stages of square root
// for the norm, a dividend stage, 15 stages of restoring division (one
// quotient bit per stage, four lanes) and the output register. That is 68
// register stages.
// One item is accepted per cycle for as long as rsp is taken; the rate is
// set by the single shared pipeline enable.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; the block accepts right after reset.
module rotation_matrix_to_quaternion (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // m11, m12, m13, m21, m22, m23, m31, m32, m33, 16 bits each, from bit 0
   input  wire logic [rmq_pkg::InW-1:0]  req_tdata,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // quat_s, quat_a, quat_b, quat_c, 16 bits each, from bit 0
   output      logic [rmq_pkg::RspW-1:0] rsp_tdata
);
   import rmq_pkg::*;

   // Shared enable: every stage moves unless a result waits and is not taken.
   logic adv;
   assign adv        = ~rsp_tvalid | rsp_tready;
   assign req_tready = adv;

   // Front stage: diagonal combinations and sign flags.
   logic signed [MatW-1:0] m [NumM];
   logic signed [SumW-1:0] sr [NumQ];
   logic [SW-1:0]          s1_s_in [NumQ];
   logic [SbW-1:0]         s1_sb_in;
   logic signed [SW-1:0]   d32, d13, d21, p21, p13, p32;

   always_comb begin
      for (int i = 0; i < NumM; i++) begin
         m[i] = req_tdata[i*MatW +: MatW];
      end
      sr[0] = SumW'(m[0]) + SumW'(m[4]) + SumW'(m[8]) + SumW'(OneQ);
      sr[1] = SumW'(m[0]) - SumW'(m[4]) - SumW'(m[8]) + SumW'(OneQ);
      sr[2] = -SumW'(m[0]) + SumW'(m[4]) - SumW'(m[8]) + SumW'(OneQ);
      sr[3] = -SumW'(m[0]) - SumW'(m[4]) + SumW'(m[8]) + SumW'(OneQ);
      for (int i = 0; i < NumQ; i++) begin
         s1_s_in[i] = sr[i][SumW-1] ? '0 : sr[i][SW-1:0];
      end
      d32 = SW'(m[7]) - SW'(m[5]);
      d13 = SW'(m[2]) - SW'(m[6]);
      d21 = SW'(m[3]) - SW'(m[1]);
      p21 = SW'(m[3]) + SW'(m[1]);
      p13 = SW'(m[2]) + SW'(m[6]);
      p32 = SW'(m[7]) + SW'(m[5]);
      s1_sb_in[SbD32] = d32[SW-1];
      s1_sb_in[SbD13] = d13[SW-1];
      s1_sb_in[SbD21] = d21[SW-1];
      s1_sb_in[SbP21] = p21[SW-1];
      s1_sb_in[SbP13] = p13[SW-1];
      s1_sb_in[SbP32] = p32[SW-1];
   end

   logic           s1_v_ff;
   logic [SW-1:0]  s1_s_ff [NumQ];
   logic [SbW-1:0] s1_sb_ff;

   // Largest component (first maximum wins) and the resulting sign flags.
   logic [1:0]      kmax;
   logic [NumQ-1:0] neg_in;

   always_comb begin
      kmax = 2'd0;
      for (int i = 1; i < NumQ; i++) begin
         if (s1_s_ff[i] > s1_s_ff[kmax]) begin
            kmax = 2'(i);
         end
      end
      unique case (kmax)
         2'd0: neg_in = {s1_sb_ff[SbD21], s1_sb_ff[SbD13], s1_sb_ff[SbD32], 1'b0};
         2'd1: neg_in = {s1_sb_ff[SbP13], s1_sb_ff[SbP21], 1'b0, s1_sb_ff[SbD32]};
         2'd2: neg_in = {s1_sb_ff[SbP32], 1'b0, s1_sb_ff[SbP21], s1_sb_ff[SbD13]};
         default: neg_in = {1'b0, s1_sb_ff[SbP32], s1_sb_ff[SbP13], s1_sb_ff[SbD21]};
      endcase
   end

   // Component magnitudes: four square roots, one root bit per stage.
   sqrt_lane_type   a1_ff [RtW][NumQ];
   sqrt_lane_type   a1_in [RtW][NumQ];
   logic [NumQ-1:0] a1_neg_ff [RtW];
   logic [RtW-1:0]  a1_v_ff;
   sqrt_lane_type   a1_first [NumQ];

   always_comb begin
      for (int i = 0; i < NumQ; i++) begin
         a1_first[i].x    = {{PadW{1'b0}}, s1_s_ff[i], {(2*FracW){1'b0}}};
         a1_first[i].rem  = '0;
         a1_first[i].root = '0;
         a1_in[0][i]      = sqrt_step(a1_first[i]);
      end
      for (int j = 1; j < RtW; j++) begin
         for (int i = 0; i < NumQ; i++) begin
            a1_in[j][i] = sqrt_step(a1_ff[j-1][i]);
         end
      end
   end

   // Squares of the magnitudes.
   logic            sq_v_ff;
   logic [XW-1:0]   sq_ff [NumQ];
   logic [RtW-1:0]  sq_mag_ff [NumQ];
   logic [NumQ-1:0] sq_neg_ff;

   // Sum of squares.
   logic            sm_v_ff;
   logic [XW-1:0]   sm_sum_ff;
   logic [RtW-1:0]  sm_mag_ff [NumQ];
   logic [NumQ-1:0] sm_neg_ff;

   // Norm: one more square root.
   sqrt_lane_type   a2_ff [RtW];
   sqrt_lane_type   a2_in [RtW];
   logic [RtW-1:0]  a2_mag_ff [RtW][NumQ];
   logic [NumQ-1:0] a2_neg_ff [RtW];
   logic [RtW-1:0]  a2_v_ff;
   sqrt_lane_type   a2_first;

   always_comb begin
      a2_first.x    = sm_sum_ff;
      a2_first.rem  = '0;
      a2_first.root = '0;
      a2_in[0]      = sqrt_step(a2_first);
      for (int j = 1; j < RtW; j++) begin
         a2_in[j] = sqrt_step(a2_ff[j-1]);
      end
   end

   // Dividend: magnitude scaled to Q.14 plus half the norm for rounding.
   logic            dp_v_ff;
   logic [NumW-1:0] dp_num_ff [NumQ];
   logic [RtW-1:0]  dp_r_ff;
   logic [NumQ-1:0] dp_neg_ff;
   logic [RtW-1:0]  r_last;
   assign r_last = a2_ff[RtW-1].root;

   // Restoring division, one quotient bit per stage, MSB first.
   logic [NumW-1:0] dv_rem_ff [QW][NumQ];
   logic [QW-1:0]   dv_q_ff [QW][NumQ];
   logic [RtW-1:0]  dv_r_ff [QW];
   logic [NumQ-1:0] dv_neg_ff [QW];
   logic [QW-1:0]   dv_v_ff;
   logic [NumW-1:0] dv_rem_in [QW][NumQ];
   logic [QW-1:0]   dv_q_in [QW][NumQ];

   always_comb begin
      logic [NumW-1:0] rem_prev;
      logic [QW-1:0]   q_prev;
      logic [RtW-1:0]  r_prev;
      logic [NumW:0]   trial;
      for (int t = 0; t < QW; t++) begin
         for (int i = 0; i < NumQ; i++) begin
            if (t == 0) begin
               rem_prev = dp_num_ff[i];
               q_prev   = '0;
               r_prev   = dp_r_ff;
            end else begin
               rem_prev = dv_rem_ff[t-1][i];
               q_prev   = dv_q_ff[t-1][i];
               r_prev   = dv_r_ff[t-1];
            end
            trial = (NumW+1)'(r_prev) << (QW - 1 - t);
            if ({1'b0, rem_prev} >= trial) begin
               dv_rem_in[t][i] = NumW'({1'b0, rem_prev} - trial);
               dv_q_in[t][i]   = {q_prev[QW-2:0], 1'b1};
            end else begin
               dv_rem_in[t][i] = rem_prev;
               dv_q_in[t][i]   = {q_prev[QW-2:0], 1'b0};
            end
         end
      end
   end

   // Output: sign applied, zero norm gives zeros.
   logic                out_v_ff;
   logic [RspW-1:0]     out_data_ff;
   logic [RspW-1:0]     out_data_in;

   always_comb begin
      logic [OutW-1:0] mag;
      for (int i = 0; i < NumQ; i++) begin
         mag = OutW'(dv_q_ff[QW-1][i]);
         if (dv_r_ff[QW-1] == '0) begin
            out_data_in[i*OutW +: OutW] = '0;
         end else if (dv_neg_ff[QW-1][i]) begin
            out_data_in[i*OutW +: OutW] = OutW'(-mag);
         end else begin
            out_data_in[i*OutW +: OutW] = mag;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         a1_v_ff  <= '0;
         sq_v_ff  <= 1'b0;
         sm_v_ff  <= 1'b0;
         a2_v_ff  <= '0;
         dp_v_ff  <= 1'b0;
         dv_v_ff  <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= req_tvalid;
         a1_v_ff  <= {a1_v_ff[RtW-2:0], s1_v_ff};
         sq_v_ff  <= a1_v_ff[RtW-1];
         sm_v_ff  <= sq_v_ff;
         a2_v_ff  <= {a2_v_ff[RtW-2:0], sm_v_ff};
         dp_v_ff  <= a2_v_ff[RtW-1];
         dv_v_ff  <= {dv_v_ff[QW-2:0], dp_v_ff};
         out_v_ff <= dv_v_ff[QW-1];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_s_ff  <= s1_s_in;
         s1_sb_ff <= s1_sb_in;

         for (int j = 0; j < RtW; j++) begin
            a1_ff[j] <= a1_in[j];
         end
         a1_neg_ff[0] <= neg_in;
         for (int j = 1; j < RtW; j++) begin
            a1_neg_ff[j] <= a1_neg_ff[j-1];
         end

         for (int i = 0; i < NumQ; i++) begin
            sq_ff[i]     <= a1_ff[RtW-1][i].root * a1_ff[RtW-1][i].root;
            sq_mag_ff[i] <= a1_ff[RtW-1][i].root;
         end
         sq_neg_ff <= a1_neg_ff[RtW-1];

         sm_sum_ff <= (sq_ff[0] + sq_ff[1]) + (sq_ff[2] + sq_ff[3]);
         sm_mag_ff <= sq_mag_ff;
         sm_neg_ff <= sq_neg_ff;

         for (int j = 0; j < RtW; j++) begin
            a2_ff[j] <= a2_in[j];
         end
         a2_mag_ff[0] <= sm_mag_ff;
         a2_neg_ff[0] <= sm_neg_ff;
         for (int j = 1; j < RtW; j++) begin
            a2_mag_ff[j] <= a2_mag_ff[j-1];
            a2_neg_ff[j] <= a2_neg_ff[j-1];
         end

         for (int i = 0; i < NumQ; i++) begin
            dp_num_ff[i] <= {a2_mag_ff[RtW-1][i], {FracW{1'b0}}}
                            + NumW'(r_last >> 1);
         end
         dp_r_ff   <= r_last;
         dp_neg_ff <= a2_neg_ff[RtW-1];

         for (int t = 0; t < QW; t++) begin
            dv_rem_ff[t] <= dv_rem_in[t];
            dv_q_ff[t]   <= dv_q_in[t];
         end
         dv_r_ff[0]   <= dp_r_ff;
         dv_neg_ff[0] <= dp_neg_ff;
         for (int t = 1; t < QW; t++) begin
            dv_r_ff[t]   <= dv_r_ff[t-1];
            dv_neg_ff[t] <= dv_neg_ff[t-1];
         end

         out_data_ff <= out_data_in;
      end
   end

`ifndef ASSERT_OFF
   // An accepted item always enters the front stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_v_ff)
      else $error("accepted item did not enter the pipeline");

   // A frozen pipeline keeps its valid bits.
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(a1_v_ff) && $stable(a2_v_ff) && $stable(dv_v_ff)))
      else $error("valid bits moved during a stall");

   // The norm is never below any magnitude it divides.
   a_norm_bound: assert property (@(posedge clock) disable iff (reset)
      a2_v_ff[RtW-1] |-> (r_last >= a2_mag_ff[RtW-1][0]
         && r_last >= a2_mag_ff[RtW-1][1] && r_last >= a2_mag_ff[RtW-1][2]
         && r_last >= a2_mag_ff[RtW-1][3]))
      else $error("norm below a component magnitude");

   // No component magnitude leaves the divider above one.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      dv_v_ff[QW-1] |-> (dv_q_ff[QW-1][0] <= QW'(OneQ)
         && dv_q_ff[QW-1][1] <= QW'(OneQ) && dv_q_ff[QW-1][2] <= QW'(OneQ)
         && dv_q_ff[QW-1][3] <= QW'(OneQ)))
      else $error("component magnitude above one");
`endif

endmodule

`default_nettype wire
